// File: hdl/circular_deque_defines.svh
// ----------------------------------------------------------------------------
// circular_deque_defines.svh
// Assertion macros used by the circular deque top module.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CDQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular_deque: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular_deque: next-cycle check failed");

`endif

// File: hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque modules.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Default sizing of the ring store.
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Width of the value fields on the ports.
  localparam int FIELD_WIDTH = 32;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    CTL_IDLE  = 1'b0,
    CTL_REPLY = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_push;
    logic do_pop;
    logic at_front;
    logic reject_full;
    logic reject_empty;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } flags_t;

endpackage

// File: hdl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue held in a ring store of CAPACITY entries.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   command selects push front, push rear, pop front or pop rear; push_value
//   is stored by a push and ignored by a pop.
//   Each request gives one result in the cycle after it is taken: done is high for exactly
//   that cycle, with pop_value, status, occupancy, is_empty and is_full.
//   A push into a full store or a pop from an empty one changes nothing and
//   reports the matching status with pop_value zero.
//   The result fields are registered; pop_value comes from the registered read port of the store.
//   Throughput is one request per cycle: busy stays low, and a request may
//   be taken in the same cycle that shows the previous result.
//   The receiver cannot stall; each result is valid only while done is high.
//   Synchronous reset empties the queue and clears both indices; the store
//   contents are not cleared, since an entry is only read after a push.
// ----------------------------------------------------------------------------
`include "circular_deque_defines.svh"

module circular_deque #(
  parameter int CAPACITY   = cdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             command,
  input  logic signed [cdq_pkg::FIELD_WIDTH-1:0] push_value,
  output logic                                   done,
  output logic signed [cdq_pkg::FIELD_WIDTH-1:0] pop_value,
  output logic [1:0]                             status,
  output logic [$clog2(CAPACITY+1)-1:0]          occupancy,
  output logic                                   is_empty,
  output logic                                   is_full
);

  cdq_pkg::ctl_t   ctl;
  cdq_pkg::flags_t flags;

  // Request decode and result strobe.
  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .flags   (flags),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  // Indices, count and ring store.
  cdq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .push_value (push_value),
    .flags      (flags),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  assign is_empty = flags.empty;
  assign is_full  = flags.full;

  // The count never exceeds the capacity.
  `CDQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, occupancy <= CAPACITY)

  // A rejected request never returns a value.
  `CDQ_ASSERT_IMPLY(a_reject_zero, clk, rst, done && (status != cdq_pkg::ST_DONE), pop_value == '0)

  // An accepted push into a store with room grows the count by one.
  `CDQ_ASSERT_NEXT(a_push_grows, clk, rst, start && !busy && !command[1] && !is_full, occupancy == $past(occupancy) + 1'b1)

  // An accepted pop from a store with entries shrinks the count by one.
  `CDQ_ASSERT_NEXT(a_pop_shrinks, clk, rst, start && !busy && command[1] && !is_empty, occupancy == $past(occupancy) - 1'b1)

endmodule

// File: hdl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: accepts requests, decodes the command against the store
// flags and strobes the result in the cycle after acceptance.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    command,
  input  cdq_pkg::flags_t flags,
  output cdq_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;
  logic            accept;

  // The datapath completes each request at the edge that takes it, so a new request
  // can be taken in any cycle, including the one that shows a result.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, result strobe and command decode.
  always_comb begin
    state_next = accept ? cdq_pkg::CTL_REPLY : cdq_pkg::CTL_IDLE;
    done       = (state == cdq_pkg::CTL_REPLY);
    ctl        = '0;
    if (accept) begin
      unique case (cdq_pkg::cmd_t'(command))
        cdq_pkg::CMD_PUSH_FRONT: begin
          ctl.do_push     = !flags.full;
          ctl.reject_full = flags.full;
          ctl.at_front    = 1'b1;
        end
        cdq_pkg::CMD_PUSH_REAR: begin
          ctl.do_push     = !flags.full;
          ctl.reject_full = flags.full;
        end
        cdq_pkg::CMD_POP_FRONT: begin
          ctl.do_pop       = !flags.empty;
          ctl.reject_empty = flags.empty;
          ctl.at_front     = 1'b1;
        end
        cdq_pkg::CMD_POP_REAR: begin
          ctl.do_pop       = !flags.empty;
          ctl.reject_empty = flags.empty;
        end
        default: begin
          ctl = '0;
        end
      endcase
    end
  end

endmodule

// File: hdl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Datapath: head and tail indices, entry count, ring store and the
// registered result fields.
// ----------------------------------------------------------------------------
module cdq_datapath #(
  parameter int CAPACITY   = cdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cdq_pkg::ctl_t                        ctl,
  input  logic signed [cdq_pkg::FIELD_WIDTH-1:0] push_value,
  output cdq_pkg::flags_t                      flags,
  output logic signed [cdq_pkg::FIELD_WIDTH-1:0] pop_value,
  output logic [1:0]                           status,
  output logic [$clog2(CAPACITY+1)-1:0]        occupancy
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = cdq_pkg::FIELD_WIDTH;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [IW-1:0] ZERO_IDX = '0;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic [IW-1:0]         head;
  logic [IW-1:0]         head_next;
  logic [IW-1:0]         tail;
  logic [IW-1:0]         tail_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  cdq_pkg::status_t      status_q;
  logic                  pop_ok;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic [FW-1:0]         rdata_ext;

  // Ring index step forward with wrap.
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? ZERO_IDX : i + IW'(1);
  endfunction

  // Ring index step backward with wrap.
  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == ZERO_IDX) ? LAST_IDX : i - IW'(1);
  endfunction

  // Fit the port value to the stored width and back.
  if (DATA_WIDTH > FW) begin : g_wide
    assign wdata     = {{(DATA_WIDTH - FW){1'b0}}, push_value};
    assign rdata_ext = rdata[FW-1:0];
  end else if (DATA_WIDTH == FW) begin : g_same
    assign wdata     = push_value;
    assign rdata_ext = rdata;
  end else begin : g_narrow
    assign wdata     = push_value[DATA_WIDTH-1:0];
    assign rdata_ext = {{(FW - DATA_WIDTH){1'b0}}, rdata};
  end

  // Flags of the current contents, used by the next request and the result.
  assign flags.empty = (count == '0);
  assign flags.full  = (count == FULL_CNT);

  // Index, count and store port update for one request.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    we         = 1'b0;
    waddr      = head;
    raddr      = ctl.at_front ? head : tail;
    if (ctl.do_push) begin
      we         = 1'b1;
      count_next = count + ONE_CNT;
      if (count == '0) begin
        head_next = ZERO_IDX;
        tail_next = ZERO_IDX;
        waddr     = ZERO_IDX;
      end else if (ctl.at_front) begin
        head_next = idx_dec(head);
        waddr     = head_next;
      end else begin
        tail_next = idx_inc(tail);
        waddr     = tail_next;
      end
    end else if (ctl.do_pop) begin
      count_next = count - ONE_CNT;
      if (count > ONE_CNT) begin
        if (ctl.at_front) begin
          head_next = idx_inc(head);
        end else begin
          tail_next = idx_dec(tail);
        end
      end
    end
  end

  // Index, count and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      status_q <= cdq_pkg::ST_DONE;
      pop_ok   <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (ctl.do_push || ctl.do_pop || ctl.reject_full || ctl.reject_empty) begin
        pop_ok <= ctl.do_pop;
        if (ctl.reject_full) begin
          status_q <= cdq_pkg::ST_FULL;
        end else if (ctl.reject_empty) begin
          status_q <= cdq_pkg::ST_EMPTY;
        end else begin
          status_q <= cdq_pkg::ST_DONE;
        end
      end
    end
  end

  // Ring store.
  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.do_pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result fields; the count already reflects the request being reported.
  assign pop_value = pop_ok ? rdata_ext : '0;
  assign status    = status_q;
  assign occupancy = count;

endmodule

// File: verif/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Watches the request and result ports of the circular deque, keeps its own
// copy of the ring store and both indices, works out the result of every
// request it sees taken, and compares each strobed result with the oldest
// result still owed.
// ----------------------------------------------------------------------------
module cdq_checker #(
  parameter int CAPACITY   = cdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [1:0]                      command,
  input  logic [cdq_pkg::FIELD_WIDTH-1:0] push_value,
  input  logic                            done,
  input  logic [cdq_pkg::FIELD_WIDTH-1:0] pop_value,
  input  logic [1:0]                      status,
  input  logic [$clog2(CAPACITY+1)-1:0]   occupancy,
  input  logic                            is_empty,
  input  logic                            is_full,
  output int                              fail_count,
  output int                              results_owed,
  output int                              request_count,
  output int                              data_pops,
  output int                              full_refusals,
  output int                              empty_refusals
);

  localparam int FW    = cdq_pkg::FIELD_WIDTH;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [FW-1:0] VALUE_MASK =
    (DATA_WIDTH >= FW) ? '1 : ((FW'(1) << DATA_WIDTH) - FW'(1));

  // One result as the deque should report it.
  typedef struct {
    logic [FW-1:0]     value;
    cdq_pkg::status_t  st;
    logic [OCC_W-1:0]  occ;
    logic              empty;
    logic              full;
  } deque_result_t;

  // Shadow copy of the deque state.
  logic [FW-1:0] ring [CAPACITY];
  int            front_idx;
  int            rear_idx;
  int            entries;

  deque_result_t owed_results[$];

  function automatic int wrap_up(int i);
    return (i >= CAPACITY - 1) ? 0 : i + 1;
  endfunction

  function automatic int wrap_down(int i);
    return (i == 0) ? CAPACITY - 1 : i - 1;
  endfunction

  // Applies one request to the shadow deque and returns the result it owes.
  function automatic deque_result_t apply_command(cdq_pkg::cmd_t c, logic [FW-1:0] v);
    deque_result_t r;
    r.value = '0;
    r.st    = cdq_pkg::ST_DONE;
    if (c == cdq_pkg::CMD_PUSH_FRONT || c == cdq_pkg::CMD_PUSH_REAR) begin
      if (entries >= CAPACITY) begin
        r.st = cdq_pkg::ST_FULL;
      end else begin
        // A push into an empty deque restarts both ends at slot zero.
        if (entries == 0) begin
          front_idx = 0;
          rear_idx  = 0;
          ring[0]   = v & VALUE_MASK;
        end else if (c == cdq_pkg::CMD_PUSH_FRONT) begin
          front_idx       = wrap_down(front_idx);
          ring[front_idx] = v & VALUE_MASK;
        end else begin
          rear_idx       = wrap_up(rear_idx);
          ring[rear_idx] = v & VALUE_MASK;
        end
        entries++;
      end
    end else begin
      if (entries == 0) begin
        r.st = cdq_pkg::ST_EMPTY;
      end else begin
        // Popping the last entry leaves the indices where they are.
        if (c == cdq_pkg::CMD_POP_FRONT) begin
          r.value = ring[front_idx];
          if (entries > 1) front_idx = wrap_up(front_idx);
        end else begin
          r.value = ring[rear_idx];
          if (entries > 1) rear_idx = wrap_down(rear_idx);
        end
        entries--;
      end
    end
    r.occ   = OCC_W'(entries);
    r.empty = (entries == 0);
    r.full  = (entries >= CAPACITY);
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, logic [FW-1:0] got, logic [FW-1:0] want);
    $display("%0t ns: circular_deque %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count     = 0;
    results_owed   = 0;
    request_count  = 0;
    data_pops      = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    front_idx      = 0;
    rear_idx       = 0;
    entries        = 0;
  end

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      front_idx = 0;
      rear_idx  = 0;
      entries   = 0;
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request outstanding", pop_value, '0);
        end else begin
          want = owed_results.pop_front();
          if (pop_value !== want.value) report_mismatch("pop_value", pop_value, want.value);
          if (status !== want.st) report_mismatch("status", FW'(status), FW'(want.st));
          if (occupancy !== want.occ) begin
            report_mismatch("occupancy", FW'(occupancy), FW'(want.occ));
          end
          if (is_empty !== want.empty) begin
            report_mismatch("is_empty", FW'(is_empty), FW'(want.empty));
          end
          if (is_full !== want.full) report_mismatch("is_full", FW'(is_full), FW'(want.full));
        end
      end
      if (start && !busy) begin
        want = apply_command(cdq_pkg::cmd_t'(command), push_value);
        owed_results.push_back(want);
        request_count++;
        if (want.st == cdq_pkg::ST_FULL) full_refusals++;
        else if (want.st == cdq_pkg::ST_EMPTY) empty_refusals++;
        else if (command == cdq_pkg::CMD_POP_FRONT || command == cdq_pkg::CMD_POP_REAR) begin
          data_pops++;
        end
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the circular deque with a short directed sequence over the empty,
// full and wrap-around cases, then with bursts of random requests biased
// toward filling or draining, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_REQUESTS = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = cdq_pkg::CMD_PUSH_FRONT;
  logic [31:0] push_value = '0;
  logic        done;
  logic [31:0] pop_value;
  logic [1:0]  status;
  logic [4:0]  occupancy;
  logic        is_empty;
  logic        is_full;
  logic        took = 1'b0;

  int fail_count;
  int results_owed;
  int request_count;
  int data_pops;
  int full_refusals;
  int empty_refusals;

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  circular_deque u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .push_value (push_value),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  cdq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .push_value     (push_value),
    .done           (done),
    .pop_value      (pop_value),
    .status         (status),
    .occupancy      (occupancy),
    .is_empty       (is_empty),
    .is_full        (is_full),
    .fail_count     (fail_count),
    .results_owed   (results_owed),
    .request_count  (request_count),
    .data_pops      (data_pops),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  // Remembers whether the last rising edge took a request.
  always @(posedge clk) begin
    took <= !rst && start && !busy;
  end

  // Presents one request at a falling edge and holds it until it is taken.
  task automatic send_request(cdq_pkg::cmd_t c, logic [31:0] v);
    start      <= 1'b1;
    command    <= c;
    push_value <= v;
    do @(negedge clk); while (!took);
  endtask

  // Leaves start low for the given number of cycles.
  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Mostly random data, now and then a boundary value.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mode 0 leans toward pushes, mode 1 toward pops, mode 2 is even.
  function automatic cdq_pkg::cmd_t pick_command(int mode);
    int  roll;
    bit  is_push;
    bit  at_front;
    roll     = $urandom_range(0, 99);
    is_push  = (mode == 0) ? (roll < 75) : (mode == 1) ? (roll < 25) : (roll < 50);
    at_front = 1'($urandom_range(0, 1));
    if (is_push) return at_front ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
    return at_front ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_REAR;
  endfunction

  // Stops sending until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  initial begin
    int  sent;
    int  burst_len;
    int  mode;
    bit  no_gaps;
    bit  drained;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pops on an empty deque, a lone entry, then fill past full.
    send_request(cdq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_request(cdq_pkg::CMD_POP_REAR, 32'h1234_5678);
    send_request(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(cdq_pkg::CMD_POP_REAR, '0);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_request(cdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF - i);
        1: send_request(cdq_pkg::CMD_PUSH_REAR, 32'h8000_0000 + i);
        2: send_request(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        default: send_request(cdq_pkg::CMD_PUSH_REAR, $urandom);
      endcase
    end
    send_request(cdq_pkg::CMD_PUSH_REAR, 32'hDEAD_BEEF);
    send_request(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
    send_request(cdq_pkg::CMD_POP_FRONT, '0);
    send_request(cdq_pkg::CMD_POP_REAR, '0);
    drain();

    // Random bursts; one stretch near the middle runs with no gaps.
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(1, 24);
      mode      = $urandom_range(0, 2);
      no_gaps   = (sent > 300 && sent < 420);
      for (int i = 0; i < burst_len; i++) begin
        send_request(pick_command(mode), pick_value());
        sent++;
      end
      if (!drained && sent >= RANDOM_REQUESTS / 2) begin
        drain();
        drained = 1'b1;
      end else if (!no_gaps) begin
        pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
      end
    end

    // Let the last result arrive, then wait on for stray strobes.
    drain();
    repeat (4) @(negedge clk);

    $display("Covered %0d requests: %0d pops returned data, %0d pushes refused as full,",
             request_count, data_pops, full_refusals);
    $display("and %0d pops refused as empty, with bursts, gaps and one full drain.",
             empty_refusals);
    if (fail_count == 0) begin
      $display("circular_deque verification clean");
    end else begin
      $display("circular_deque verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("circular_deque verification failed");
    $finish;
  end

endmodule
